/* rtl/core/pq_lookup_distance_scan_macros.svh */
// Assertion macros for the checker file of the distance scan.
`ifndef PQ_LOOKUP_DISTANCE_SCAN_MACROS_SVH
`define PQ_LOOKUP_DISTANCE_SCAN_MACROS_SVH

// Checked on every clock edge while the block is out of reset.
`define PQS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every clock edge, including those inside reset.
`define PQS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/pqs_pkg.sv */
package pqs_pkg;

  localparam int unsigned IDX_W      = 9;
  localparam int unsigned VAL_W      = 8;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned SUM_W      = 13;
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [SUM_W-1:0] SUM_MAX   = 13'h1FFF;
  localparam logic [CFG_W-1:0] LEN_RESET = 5'd16;

  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_CODE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    OP_CODE,
    OP_WRITE_EVEN,
    OP_WRITE_ODD
  } op_kind_e;

  // One queued operation; value is the table value for writes and the code byte otherwise.
  typedef struct packed {
    op_kind_e          kind;
    logic [IDX_W-1:0]  index;
    logic [VAL_W-1:0]  value;
  } op_t;

endpackage

/* rtl/core/pqs_ram.sv */
module pqs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/pqs_front.sv */
module pqs_front #(
  parameter int unsigned MAX_CODE_BYTES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [pqs_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  input  logic                               s_axis_tuser_i,
  input  logic                               pop_i,
  output logic                               head_valid_o,
  output pqs_pkg::op_t                       head_o
);

  import pqs_pkg::*;

  localparam int unsigned TABLE_DEPTH = MAX_CODE_BYTES * 32;

  cmd_e             cmd;
  logic [IDX_W-1:0] index;
  logic [VAL_W-1:0] table_value;
  logic [VAL_W-1:0] code_byte;
  logic             in_range;
  logic             push;
  op_t              op;

  op_t        entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign cmd         = cmd_e'(s_axis_tuser_i);
  assign index       = s_axis_tdata_i[IDX_W-1:0];
  assign table_value = s_axis_tdata_i[IDX_W+VAL_W-1:IDX_W];
  assign code_byte   = s_axis_tdata_i[IDX_W+2*VAL_W-1:IDX_W+VAL_W];
  assign in_range    = 32'(index) < TABLE_DEPTH;

  // Codebook parity (index bit 4) picks the bank that a table write lands in.
  always_comb begin
    op.index = index;
    if (cmd == CMD_CODE) begin
      op.kind  = OP_CODE;
      op.value = code_byte;
    end else begin
      op.kind  = index[NIB_W] ? OP_WRITE_ODD : OP_WRITE_EVEN;
      op.value = table_value;
    end
  end

  assign s_axis_tready_o = (cnt_q != 2'd2);
  // Writes beyond the table are accepted and dropped here.
  assign push = s_axis_tvalid_i && s_axis_tready_o && ((cmd == CMD_CODE) || in_range);

  always_comb begin
    wr_ptr_d = push  ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= op;
    end
  end

  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = entry_q[rd_ptr_q];

endmodule

/* rtl/core/pqs_back.sv */
module pqs_back #(
  parameter int unsigned MAX_CODE_BYTES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [pqs_pkg::CFG_W-1:0]          len_i,
  input  logic                               head_valid_i,
  input  pqs_pkg::op_t                       head_i,
  output logic                               pop_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [pqs_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);

  import pqs_pkg::*;

  localparam int unsigned PW         = (MAX_CODE_BYTES > 1) ? $clog2(MAX_CODE_BYTES) : 1;
  localparam int unsigned BANK_DEPTH = MAX_CODE_BYTES * 16;
  localparam int unsigned BAW        = $clog2(BANK_DEPTH);

  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] pos_next;
  logic             code_last;
  logic             pop_code;

  logic [PW-1:0]    pos_q, pos_d;
  logic             s1_valid_q, s1_valid_d;
  logic             s1_last_q, s1_last_d;
  logic [SUM_W-1:0] acc_q, acc_d;
  logic             out_valid_q, out_valid_d;
  logic [SUM_W-1:0] out_data_q;

  logic             out_free;
  logic             s1_adv;
  logic             emit;

  logic [BAW-1:0]   waddr;
  logic [BAW-1:0]   raddr_even, raddr_odd;
  logic [VAL_W-1:0] rdata_even, rdata_odd;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;

  // A zero length counts as one byte; lengths above the table clamp to its size.
  always_comb begin
    if (len_i == '0) begin
      len_eff = LEN_W'(1);
    end else if (LEN_W'(len_i) > LEN_W'(MAX_CODE_BYTES)) begin
      len_eff = LEN_W'(MAX_CODE_BYTES);
    end else begin
      len_eff = LEN_W'(len_i);
    end
  end

  assign pos_next  = LEN_W'(pos_q) + LEN_W'(1);
  assign code_last = (pos_next >= len_eff);

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s1_adv   = s1_valid_q && (!s1_last_q || out_free);
  assign emit     = s1_adv && s1_last_q;
  assign pop_o    = head_valid_i && (!s1_valid_q || s1_adv);
  assign pop_code = pop_o && (head_i.kind == OP_CODE);

  assign waddr      = BAW'({head_i.index[IDX_W-1:NIB_W+1], head_i.index[NIB_W-1:0]});
  assign raddr_even = BAW'({pos_q, head_i.value[NIB_W-1:0]});
  assign raddr_odd  = BAW'({pos_q, head_i.value[VAL_W-1:NIB_W]});

  pqs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_even (
    .clk_i   (clk_i),
    .we_i    (pop_o && (head_i.kind == OP_WRITE_EVEN)),
    .waddr_i (waddr),
    .wdata_i (head_i.value),
    .re_i    (pop_code),
    .raddr_i (raddr_even),
    .rdata_o (rdata_even)
  );

  pqs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_odd (
    .clk_i   (clk_i),
    .we_i    (pop_o && (head_i.kind == OP_WRITE_ODD)),
    .waddr_i (waddr),
    .wdata_i (head_i.value),
    .re_i    (pop_code),
    .raddr_i (raddr_odd),
    .rdata_o (rdata_odd)
  );

  assign sum_wide = (SUM_W+1)'(acc_q) + (SUM_W+1)'(rdata_even) + (SUM_W+1)'(rdata_odd);
  assign sum_sat  = (sum_wide > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];

  always_comb begin
    pos_d       = pos_q;
    s1_valid_d  = s1_valid_q;
    s1_last_d   = s1_last_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;

    if (pop_code) begin
      pos_d = code_last ? '0 : PW'(pos_next);
    end

    if (pop_o) begin
      s1_valid_d = pop_code;
      s1_last_d  = code_last;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    if (s1_adv) begin
      acc_d = s1_last_q ? '0 : sum_sat;
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      s1_valid_q  <= s1_valid_d;
      s1_last_q   <= s1_last_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= sum_sat;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(out_data_q);

endmodule

/* rtl/core/pq_lookup_distance_scan.sv */
// Channel   Direction  Payload
// s_axis    in         tuser: cmd; tdata: table_index, table_value, code_byte
// m_axis    out        tdata: distance_sum
// cfg       in         data: code_bytes_in_use
//
// One s_axis beat per cycle is taken in steady state while m_axis does not stall.
// A code's sum reaches m_axis once the beat of its last byte has passed the input queue
// and the registered reads of the two table banks, which are added into the output register.
// Reset clears the queue, the byte position, the partial sum and the output.
// The two-entry queue lets s_axis keep flowing while m_axis stalls, until both entries are full.
module pq_lookup_distance_scan #(
  parameter int unsigned MAX_CODE_BYTES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [8:0] table_index, [16:9] table_value, [24:17] code_byte, rest zero
  input  logic [pqs_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // [0] cmd
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [12:0] distance_sum, rest zero
  output logic [pqs_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pqs_pkg::CFG_W-1:0]          cfg_data_i
);

  import pqs_pkg::*;

  logic [CFG_W-1:0] len_q;
  logic             head_valid;
  op_t              head;
  logic             pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_valid_i) begin
      len_q <= cfg_data_i;
    end
  end

  pqs_front #(
    .MAX_CODE_BYTES (MAX_CODE_BYTES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .pop_i           (pop),
    .head_valid_o    (head_valid),
    .head_o          (head)
  );

  pqs_back #(
    .MAX_CODE_BYTES (MAX_CODE_BYTES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .len_i           (len_q),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

/* rtl/core/pqs_checker.sv */
`include "pq_lookup_distance_scan_macros.svh"

module pqs_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  input  logic                               s_axis_tready_o,
  input  logic [pqs_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  input  logic                               s_axis_tuser_i,
  input  logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  input  logic [pqs_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_o,
  input  logic [pqs_pkg::CFG_W-1:0]          cfg_data_i
);

  import pqs_pkg::*;

  // No sum can leave the block in the cycle right after reset.
  `PQS_ASSERT_ALWAYS(a_quiet_after_reset, !rst_ni |=> !m_axis_tvalid_o, "output beat right after reset")

  // A stalled result beat keeps its sum.
  `PQS_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled output beat changed")

  // Sums are held in a 13-bit field and zero-extended, so the padding bits stay clear.
  `PQS_ASSERT(a_sum_range, m_axis_tvalid_o |-> (m_axis_tdata_o[OUT_DATA_W-1:SUM_W] == '0), "sum padding bits set")

  // The length register is always writable.
  `PQS_ASSERT(a_cfg_ready, cfg_valid_i |-> cfg_ready_o, "configuration write refused")

endmodule

bind pq_lookup_distance_scan pqs_checker u_checker (.*);

/* tb/pq_lookup_distance_scan_tb.sv */
module pq_lookup_distance_scan_tb;
  import pqs_pkg::*;

  localparam int unsigned MAX_CODE_BYTES = 16;
  localparam int unsigned DIST_DEPTH = MAX_CODE_BYTES * 32;
  localparam int unsigned CENTROIDS = 16;
  localparam int unsigned TOTAL_BEATS = 1800;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DIRECTED_ROWS = 14;

  typedef enum int unsigned {
    RX_OPEN,
    RX_PATTERN,
    RX_RANDOM
  } rx_mode_e;

  // One directed beat; sum is the known result when checked is set.
  typedef struct packed {
    cmd_e             cmd;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] code;
    logic             checked;
    logic [SUM_W-1:0] sum;
  } scan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  // [8:0] table_index, [16:9] table_value, [24:17] code_byte, rest zero
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  // [0] cmd
  logic                  s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  // [12:0] distance_sum, rest zero
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_W-1:0]      cfg_data_i;

  pq_lookup_distance_scan #(
    .MAX_CODE_BYTES(MAX_CODE_BYTES)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Shadow copy of the block state.
  logic [VAL_W-1:0] dist_mem [DIST_DEPTH];
  int unsigned      code_pos;
  int unsigned      partial_sum;
  logic [CFG_W-1:0] code_len_reg;

  logic [SUM_W-1:0] expected_sums [$];
  logic [SUM_W-1:0] listed_sums [$];
  int unsigned      mismatches;
  int unsigned      cycle_count;
  int unsigned      beats_sent;
  int unsigned      burst_left;
  bit               gaps_on;

  bit               hold_request;
  int unsigned      hold_left;
  int unsigned      rx_tick;
  rx_mode_e         rx_mode;
  logic [7:0]       rx_mask;

  logic [SUM_W-1:0] got_sum;
  logic [SUM_W-1:0] want_sum;

  scan_row_t directed_rows [DIRECTED_ROWS];

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // Adds one code byte into the partial distance, or loads one table entry.
  function automatic void accumulate_beat(input cmd_e cmd, input logic [IDX_W-1:0] index,
                                          input logic [VAL_W-1:0] value,
                                          input logic [VAL_W-1:0] code);
    int unsigned span;
    int unsigned total;
    if (cmd == CMD_WRITE) begin
      dist_mem[index] = value;
      return;
    end
    span = 32'(code_len_reg);
    if (span < 1) span = 1;
    if (span > MAX_CODE_BYTES) span = MAX_CODE_BYTES;
    total = partial_sum
          + 32'(dist_mem[IDX_W'((2 * code_pos) * CENTROIDS + code[3:0])])
          + 32'(dist_mem[IDX_W'((2 * code_pos + 1) * CENTROIDS + code[7:4])]);
    if (total > SUM_MAX) total = 32'(SUM_MAX);
    if (code_pos + 1 >= span) begin
      expected_sums.push_back(total[SUM_W-1:0]);
      partial_sum = 0;
      code_pos = 0;
    end else begin
      partial_sum = total;
      code_pos++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_sum = m_axis_tdata_o[SUM_W-1:0];
        if (expected_sums.size() == 0) begin
          flag_mismatch("distance_sum with none pending", 32'(got_sum), 0);
        end else begin
          want_sum = expected_sums.pop_front();
          if (got_sum !== want_sum) begin
            flag_mismatch("distance_sum", 32'(got_sum), 32'(want_sum));
          end
        end
        if (listed_sums.size() != 0) begin
          want_sum = listed_sums.pop_front();
          if (got_sum !== want_sum) begin
            flag_mismatch("listed distance_sum", 32'(got_sum), 32'(want_sum));
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        accumulate_beat(cmd_e'(s_axis_tuser_i), s_axis_tdata_i[8:0],
                        s_axis_tdata_i[16:9], s_axis_tdata_i[24:17]);
      end
      if (cfg_valid_i && cfg_ready_o) code_len_reg = cfg_data_i;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: switches among open, patterned and random stall styles, and on request
  // holds off for a long stretch so that the block backs up into s_axis.
  always @(posedge clk_i) begin
    if (rx_tick % 48 == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_mask = 8'($urandom);
    end
    rx_tick++;
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: m_axis_tready_i <= 1'b1;
        RX_PATTERN: m_axis_tready_i <= rx_mask[rx_tick[2:0]];
        default: m_axis_tready_i <= ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  // Entered and left at a rising edge; leaves tvalid high for the next beat.
  task automatic send_beat(input cmd_e cmd, input logic [IDX_W-1:0] index,
                           input logic [VAL_W-1:0] value, input logic [VAL_W-1:0] code);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {7'd0, code, value, index};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (expected_sums.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_code_len(input logic [CFG_W-1:0] len);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned phase;
    int unsigned n_beats;
    logic [CFG_W-1:0] len;
    logic [CFG_W-1:0] early_lens [6];

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CMD_WRITE;
    m_axis_tready_i = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    mismatches      = 0;
    cycle_count     = 0;
    beats_sent      = 0;
    burst_left      = 0;
    gaps_on         = 1'b1;
    hold_request    = 1'b0;
    hold_left       = 0;
    rx_tick         = 0;
    code_pos        = 0;
    partial_sum     = 0;
    code_len_reg    = LEN_RESET;
    for (int i = 0; i < DIST_DEPTH; i++) dist_mem[i] = '0;
    early_lens = '{5'd2, 5'd31, 5'd1, 5'd17, 5'd3, 5'd0};

    // Length zero acts as one, so every code row below completes a code
    // built from codebooks 0 and 1 only.
    directed_rows = '{
      '{CMD_WRITE, 9'd0,   8'd255, 8'hA5, 1'b0, 13'd0},
      '{CMD_WRITE, 9'd15,  8'd0,   8'h5A, 1'b0, 13'd0},
      '{CMD_WRITE, 9'd16,  8'd255, 8'hFF, 1'b0, 13'd0},
      '{CMD_WRITE, 9'd31,  8'd0,   8'h00, 1'b0, 13'd0},
      '{CMD_WRITE, 9'd511, 8'd200, 8'h3C, 1'b0, 13'd0},
      '{CMD_CODE,  9'h1FF, 8'hFF,  8'h00, 1'b1, 13'd510},
      '{CMD_CODE,  9'h000, 8'h00,  8'hFF, 1'b1, 13'd0},
      '{CMD_CODE,  9'h155, 8'hAA,  8'hF0, 1'b1, 13'd255},
      '{CMD_CODE,  9'h0AA, 8'h55,  8'h0F, 1'b1, 13'd255},
      '{CMD_WRITE, 9'd0,   8'd0,   8'hC3, 1'b0, 13'd0},
      '{CMD_WRITE, 9'd31,  8'd7,   8'h81, 1'b0, 13'd0},
      '{CMD_CODE,  9'h1FF, 8'h00,  8'hF0, 1'b1, 13'd7},
      '{CMD_CODE,  9'h000, 8'hFF,  8'h00, 1'b1, 13'd255},
      '{CMD_CODE,  9'h123, 8'h7E,  8'hFF, 1'b1, 13'd7}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_code_len(5'd0);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].checked) listed_sums.push_back(directed_rows[i].sum);
      send_beat(directed_rows[i].cmd, directed_rows[i].index, directed_rows[i].value,
                directed_rows[i].code);
    end
    wait_drained();

    // A full-length code over a table of 255s gives the largest sum.
    write_code_len(5'd16);
    for (int i = 0; i < DIST_DEPTH; i++) begin
      send_beat(CMD_WRITE, IDX_W'(i), 8'd255, VAL_W'($urandom));
    end
    for (int i = 0; i < MAX_CODE_BYTES; i++) begin
      send_beat(CMD_CODE, IDX_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
    end
    for (int i = 0; i < DIST_DEPTH; i++) begin
      send_beat(CMD_WRITE, IDX_W'(i), pick_byte(), VAL_W'($urandom));
    end

    // Phases rarely end on a code boundary, so length changes land mid-code.
    phase = 0;
    while (beats_sent < TOTAL_BEATS) begin
      wait_drained();
      if (phase < 6) len = early_lens[phase];
      else if ($urandom_range(0, 9) < 7) len = CFG_W'($urandom_range(1, 5));
      else len = CFG_W'($urandom_range(0, 31));
      write_code_len(len);
      gaps_on = ($urandom_range(0, 3) != 0);
      n_beats = $urandom_range(40, 120);
      if (phase == 0) hold_request = 1'b1;
      for (int k = 0; k < n_beats; k++) begin
        if (phase == 2 && k == n_beats / 2) begin
          s_axis_tvalid_i <= 1'b0;
          do @(posedge clk_i); while (expected_sums.size() != 0);
        end
        if ($urandom_range(0, 99) < 85) begin
          send_beat(CMD_CODE, IDX_W'($urandom), VAL_W'($urandom), pick_byte());
        end else begin
          send_beat(CMD_WRITE, IDX_W'($urandom_range(0, DIST_DEPTH - 1)), pick_byte(),
                    VAL_W'($urandom));
        end
      end
      phase++;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && listed_sums.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
